>>> rtl/core/kat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kat_pkg;

   localparam int KEY_W   = 64;
   localparam int TOTAL_W = 32;
   localparam int SLOT_W  = 5;
   localparam int COUNT_W = 6;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef struct packed {
      logic [1:0]        action;
      logic [KEY_W-1:0]  key;
      logic [15:0]       amount;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  entry_slot;
      logic               was_new;
      logic               dropped;
      logic [KEY_W-1:0]   entry_key;
      logic [TOTAL_W-1:0] entry_total;
      logic [COUNT_W-1:0] entry_count;
      logic               winner_valid;
      logic [SLOT_W-1:0]  winner_slot;
      logic [TOTAL_W-1:0] winner_total;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/keyed_accumulate_table.sv
// Channel   Direction  Handshake             Word
// req       in         req_valid / req_stall kat_pkg::req_type (action, key, amount, slot)
// rsp       out        rsp_valid / rsp_stall kat_pkg::rsp_type (entry, count, winner)
//
// An add walks the occupied slots through the single read port of the entry
// memory, one slot a cycle, until it finds the key or passes the count.
// An in-range read passes through ST_READ; a clear or unused action does not.
// Reset clears the count and the winner; the entry memory is not swept, as only
// slots below the count are ever read.
// A new word is taken while the previous result still waits on rsp_stall.
`timescale 1ns / 1ps
`default_nettype none

module keyed_accumulate_table #(
   parameter int ENTRIES = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire kat_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output kat_pkg::rsp_type      rsp_data
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int DW = kat_pkg::KEY_W + kat_pkg::TOTAL_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                   state_ff, state_in;
   kat_pkg::req_type             item_ff, item_in;
   logic [CW-1:0]                addr_ff, addr_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [IW-1:0]                rd_slot_ff, rd_slot_in;
   logic [kat_pkg::SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic                         res_new_ff, res_new_in;
   logic                         res_drop_ff, res_drop_in;
   logic [kat_pkg::KEY_W-1:0]    res_key_ff, res_key_in;
   logic [kat_pkg::TOTAL_W-1:0]  res_total_ff, res_total_in;
   logic                         wr_pend_ff, wr_pend_in;
   logic [IW-1:0]                wr_addr_ff, wr_addr_in;
   logic [CW-1:0]                count_ff, count_in;
   logic                         best_valid_ff, best_valid_in;
   logic [IW-1:0]                best_slot_ff, best_slot_in;
   logic [kat_pkg::TOTAL_W-1:0]  best_total_ff, best_total_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   kat_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                         ram_rd_en;
   logic [IW-1:0]                ram_rd_addr;
   logic                         ram_wr_en;
   logic [DW-1:0]                ram_rd_data;
   logic [kat_pkg::KEY_W-1:0]    rd_key;
   logic [kat_pkg::TOTAL_W-1:0]  rd_total;
   logic [kat_pkg::TOTAL_W:0]    sum;
   logic                         hit;
   logic                         out_free;
   logic                         slot_in_range;

   kat_ram #(
      .WIDTH(DW),
      .DEPTH(ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data ({item_ff.key, res_total_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_key        = ram_rd_data[DW-1:kat_pkg::TOTAL_W];
   assign rd_total      = ram_rd_data[kat_pkg::TOTAL_W-1:0];
   assign sum           = {1'b0, rd_total} + {{(kat_pkg::TOTAL_W - 15){1'b0}}, item_ff.amount};
   assign hit           = rd_pend_ff && (rd_key == item_ff.key);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign slot_in_range = 32'(req_data.slot) < 32'(count_ff);
   assign req_stall     = state_ff != ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      addr_in       = addr_ff;
      rd_pend_in    = rd_pend_ff;
      rd_slot_in    = rd_slot_ff;
      res_slot_in   = res_slot_ff;
      res_new_in    = res_new_ff;
      res_drop_in   = res_drop_ff;
      res_key_in    = res_key_ff;
      res_total_in  = res_total_ff;
      wr_pend_in    = wr_pend_ff;
      wr_addr_in    = wr_addr_ff;
      count_in      = count_ff;
      best_valid_in = best_valid_ff;
      best_slot_in  = best_slot_ff;
      best_total_in = best_total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      ram_wr_en     = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in      = req_data;
               addr_in      = '0;
               rd_pend_in   = 1'b0;
               res_slot_in  = '0;
               res_new_in   = 1'b0;
               res_drop_in  = 1'b0;
               res_key_in   = '0;
               res_total_in = '0;
               wr_pend_in   = 1'b0;
               priority if (req_data.action == kat_pkg::ACT_ADD) begin
                  state_in = ST_SCAN;
               end else if (req_data.action == kat_pkg::ACT_READ) begin
                  res_slot_in = req_data.slot;
                  if (slot_in_range) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = IW'(req_data.slot);
                     state_in    = ST_READ;
                  end else begin
                     res_drop_in = 1'b1;
                     state_in    = ST_DONE;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_SCAN: begin
            // Reads are issued one slot ahead; each cycle checks the word issued
            // in the previous cycle.
            if (hit) begin
               res_slot_in  = kat_pkg::SLOT_W'(rd_slot_ff);
               res_key_in   = item_ff.key;
               res_total_in = sum[kat_pkg::TOTAL_W] ? kat_pkg::TOTAL_MAX
                                                    : sum[kat_pkg::TOTAL_W-1:0];
               wr_pend_in   = 1'b1;
               wr_addr_in   = rd_slot_ff;
               rd_pend_in   = 1'b0;
               state_in     = ST_DONE;
            end else if (addr_ff < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IW'(addr_ff);
               rd_pend_in  = 1'b1;
               rd_slot_in  = IW'(addr_ff);
               addr_in     = addr_ff + CW'(1);
            end else begin
               rd_pend_in = 1'b0;
               res_key_in = item_ff.key;
               if (count_ff < CW'(ENTRIES)) begin
                  res_slot_in  = kat_pkg::SLOT_W'(count_ff);
                  res_new_in   = 1'b1;
                  res_total_in = kat_pkg::TOTAL_W'(item_ff.amount);
                  wr_pend_in   = 1'b1;
                  wr_addr_in   = IW'(count_ff);
               end else begin
                  res_drop_in = 1'b1;
               end
               state_in = ST_DONE;
            end
         end

         ST_READ: begin
            res_key_in   = rd_key;
            res_total_in = rd_total;
            state_in     = ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               if (wr_pend_ff) begin
                  ram_wr_en = 1'b1;
                  if (res_new_ff) begin
                     count_in = count_ff + CW'(1);
                  end
                  // Totals never fall, so a running winner matches a full scan.
                  if (res_total_ff != '0 &&
                      (!best_valid_ff || res_total_ff > best_total_ff ||
                       (res_total_ff == best_total_ff && wr_addr_ff < best_slot_ff))) begin
                     best_valid_in = 1'b1;
                     best_slot_in  = wr_addr_ff;
                     best_total_in = res_total_ff;
                  end
               end
               if (item_ff.action == kat_pkg::ACT_CLEAR) begin
                  count_in      = '0;
                  best_valid_in = 1'b0;
                  best_slot_in  = '0;
                  best_total_in = '0;
               end
               rsp_data_in.entry_slot   = res_slot_ff;
               rsp_data_in.was_new      = res_new_ff;
               rsp_data_in.dropped      = res_drop_ff;
               rsp_data_in.entry_key    = res_key_ff;
               rsp_data_in.entry_total  = res_total_ff;
               rsp_data_in.entry_count  = kat_pkg::COUNT_W'(count_in);
               rsp_data_in.winner_valid = best_valid_in;
               rsp_data_in.winner_slot  = kat_pkg::SLOT_W'(best_slot_in);
               rsp_data_in.winner_total = best_total_in;
               rsp_valid_in             = 1'b1;
               wr_pend_in               = 1'b0;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_pend_ff    <= 1'b0;
         wr_pend_ff    <= 1'b0;
         count_ff      <= '0;
         best_valid_ff <= 1'b0;
         best_slot_ff  <= '0;
         best_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         wr_pend_ff    <= wr_pend_in;
         count_ff      <= count_in;
         best_valid_ff <= best_valid_in;
         best_slot_ff  <= best_slot_in;
         best_total_ff <= best_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff      <= item_in;
      addr_ff      <= addr_in;
      rd_slot_ff   <= rd_slot_in;
      res_slot_ff  <= res_slot_in;
      res_new_ff   <= res_new_in;
      res_drop_ff  <= res_drop_in;
      res_key_ff   <= res_key_in;
      res_total_ff <= res_total_in;
      wr_addr_ff   <= wr_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/kat_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module kat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/kat_check.sv
`timescale 1ns / 1ps
`default_nettype none

module kat_check #(
   parameter int ENTRIES = 32
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire kat_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire kat_pkg::rsp_type rsp_data
);

   // A result word held back by the receiver stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Without a winner the winner fields read as zero; with one the total is positive.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.winner_valid ? (rsp_data.winner_total != '0)
                     : (rsp_data.winner_total == '0 && rsp_data.winner_slot == '0)))
      else $error("winner fields inconsistent");

   // A new entry and a refusal cannot come from the same word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.was_new && rsp_data.dropped))
      else $error("result both new and dropped");

   // The occupied count never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ENTRIES < 64 |-> 32'(rsp_data.entry_count) <= ENTRIES)
      else $error("entry count beyond table size");

   // An accepted clear empties the table in the next result word.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.action == kat_pkg::ACT_CLEAR ##1 !rsp_valid
      |=> rsp_valid && rsp_data.entry_count == '0 && !rsp_data.winner_valid)
      else $error("clear did not empty the table");

endmodule

bind keyed_accumulate_table kat_check #(
   .ENTRIES(ENTRIES)
) u_kat_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
